>>> design/npq_pkg.sv
// Shared types and constants of the nearest palette quantizer.
package npq_pkg;

   // Palette geometry: entries beyond the 4-bit index reach are never searched
   localparam int PALETTE_SIZE = 16;
   localparam int INDEX_REACH  = 16;
   localparam int SEARCH_CELLS = (PALETTE_SIZE < INDEX_REACH) ? PALETTE_SIZE : INDEX_REACH;
   localparam int IDX_W        = 4;
   localparam int COMP_W       = 8;
   localparam int COLOR_W      = 3 * COMP_W;
   localparam int SQ_W         = 2 * COMP_W;
   localparam int DIST_W       = SQ_W + 2;

   // Transparency key modes; the unused code acts as no transparency
   localparam logic [1:0] KEY_MODE_NONE  = 2'd0;
   localparam logic [1:0] KEY_MODE_FIXED = 2'd1;
   localparam logic [1:0] KEY_MODE_FIRST = 2'd2;

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // Configuration register indexes
   localparam logic CSR_KEY_MODE  = 1'b0;
   localparam logic CSR_FIXED_KEY = 1'b1;

   // One item as it moves down the cell chain
   typedef struct packed {
      logic                valid;
      logic                is_pixel;
      logic                transparent;
      logic [COLOR_W-1:0]  color;     // red in the top byte
      logic [IDX_W-1:0]    slot;
      logic [IDX_W-1:0]    best_idx;
      logic [DIST_W-1:0]   best_len;
   } npq_stage_type;

endpackage

>>> design/nearest_palette_quantizer.sv
// Top level of the nearest palette quantizer: stream ports, key logic and the cell chain.
//
// Each item passes one palette cell per clock down a chain of SEARCH_CELLS cells (16 by
// default), and one item is taken every cycle while the result side keeps up. Load items
// ride the same chain and write their slot as they pass it, so every pixel sees exactly
// the palette loaded before it; loads give no result. The whole chain holds while a
// result waits, and the result register is the last cell's stage. The transparency
// key is resolved at entry, so a transparent pixel returns color_index 0 with
// is_transparent set.
module nearest_palette_quantizer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], entry_index[27:24]
   input  logic [1:0]  req_tuser,   // req_type[0], new_image[1]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // color_index[3:0]
   output logic        rsp_tuser,   // is_transparent
   // configuration
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);
   import npq_pkg::*;

   logic [1:0]          key_mode_ff;
   logic [1:0]          key_mode_in;
   logic [COLOR_W-1:0]  fixed_key_ff;
   logic [COLOR_W-1:0]  fixed_key_in;
   logic [COLOR_W-1:0]  captured_key_ff;
   logic [COLOR_W-1:0]  captured_key_in;
   logic                key_captured_ff;
   logic                key_captured_in;

   logic                advance;
   logic                accept;
   logic                is_pixel;
   logic                new_image;
   logic [COLOR_W-1:0]  color;
   logic                capture;
   logic                transparent;
   npq_stage_type       chain [SEARCH_CELLS+1];
   npq_stage_type       last;

   // Whole chain moves unless a finished result is waiting
   assign last       = chain[SEARCH_CELLS];
   assign rsp_tvalid = last.valid && (last.is_pixel == REQ_PIXEL);
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   // Unpack the request
   assign is_pixel  = req_tuser[0];
   assign new_image = req_tuser[1];
   assign color     = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};

   // Configuration writes
   always_comb begin
      key_mode_in  = key_mode_ff;
      fixed_key_in = fixed_key_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_KEY_MODE:  key_mode_in  = csr_wdata[1:0];
            CSR_FIXED_KEY: fixed_key_in = csr_wdata;
            default:       key_mode_in  = key_mode_ff;
         endcase
      end
   end

   // Resolve the transparency key and capture state for the entering pixel
   always_comb begin
      capture     = 1'b0;
      transparent = 1'b0;
      case (key_mode_ff)
         KEY_MODE_FIXED: transparent = (color == fixed_key_ff);
         KEY_MODE_FIRST: begin
            capture     = new_image || !key_captured_ff;
            transparent = capture || (color == captured_key_ff);
         end
         default: transparent = 1'b0;
      endcase
      captured_key_in = captured_key_ff;
      key_captured_in = key_captured_ff;
      if (accept && (is_pixel == REQ_PIXEL) && capture) begin
         captured_key_in = color;
         key_captured_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff     <= KEY_MODE_NONE;
         fixed_key_ff    <= '0;
         captured_key_ff <= '0;
         key_captured_ff <= 1'b0;
      end else begin
         key_mode_ff     <= key_mode_in;
         fixed_key_ff    <= fixed_key_in;
         captured_key_ff <= captured_key_in;
         key_captured_ff <= key_captured_in;
      end
   end

   // Stage entering the first cell
   always_comb begin
      chain[0].valid       = accept;
      chain[0].is_pixel    = is_pixel;
      chain[0].transparent = transparent;
      chain[0].color       = color;
      chain[0].slot        = req_tdata[27:24];
      chain[0].best_idx    = '0;
      chain[0].best_len    = '0;
   end

   // Row of palette cells
   for (genvar g = 0; g < SEARCH_CELLS; g++) begin : g_cell
      npq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (IDX_W'(g)),
         .stage_i    (chain[g]),
         .stage_o    (chain[g+1])
      );
   end

   // Drive the result
   assign rsp_tdata = {4'b0000, (last.transparent ? {IDX_W{1'b0}} : last.best_idx)};
   assign rsp_tuser = last.transparent;

`ifndef SYNTHESIS
   // A capture in first-color mode always leaves the key marked as captured
   assert property (@(posedge clock) disable iff (reset)
      accept && (is_pixel == REQ_PIXEL) && (key_mode_ff == KEY_MODE_FIRST)
      |=> key_captured_ff)
      else $error("key not marked captured after first-color pixel");

   // Once captured, the key stays captured until reset
   assert property (@(posedge clock) disable iff (reset)
      key_captured_ff |=> key_captured_ff)
      else $error("key capture flag dropped without reset");

   // A held result freezes the last stage
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(last))
      else $error("last stage moved while the result was stalled");

   // Input is refused exactly while a result waits
   assert property (@(posedge clock) disable iff (reset)
      req_tready == !(rsp_tvalid && !rsp_tready))
      else $error("request ready out of step with result stall");
`endif

endmodule

>>> design/npq_cell.sv
// One palette cell: holds one entry, loads it, and folds it into the running nearest match.
module npq_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [npq_pkg::IDX_W-1:0]    cell_index,
   input  npq_pkg::npq_stage_type       stage_i,
   output npq_pkg::npq_stage_type       stage_o
);
   import npq_pkg::*;

   logic [COLOR_W-1:0] entry_ff;
   logic [COLOR_W-1:0] entry_in;
   npq_stage_type      stage_ff;
   npq_stage_type      stage_in;

   logic [COMP_W-1:0]  diff_r;
   logic [COMP_W-1:0]  diff_g;
   logic [COMP_W-1:0]  diff_b;
   logic [SQ_W-1:0]    sq_r;
   logic [SQ_W-1:0]    sq_g;
   logic [SQ_W-1:0]    sq_b;
   logic [DIST_W-1:0]  len;
   logic               load_hit;

   // Absolute component differences against the held entry
   always_comb begin
      logic [COMP_W-1:0] pr, pg, pb, xr, xg, xb;
      pr = entry_ff[COLOR_W-1 -: COMP_W];
      pg = entry_ff[SQ_W-1 -: COMP_W];
      pb = entry_ff[COMP_W-1:0];
      xr = stage_i.color[COLOR_W-1 -: COMP_W];
      xg = stage_i.color[SQ_W-1 -: COMP_W];
      xb = stage_i.color[COMP_W-1:0];
      diff_r = (pr > xr) ? (pr - xr) : (xr - pr);
      diff_g = (pg > xg) ? (pg - xg) : (xg - pg);
      diff_b = (pb > xb) ? (pb - xb) : (xb - pb);
   end

   // Squared distance
   assign sq_r = SQ_W'(diff_r) * SQ_W'(diff_r);
   assign sq_g = SQ_W'(diff_g) * SQ_W'(diff_g);
   assign sq_b = SQ_W'(diff_b) * SQ_W'(diff_b);
   assign len  = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

   // Load items write the entry as they pass the matching cell
   assign load_hit = advance && stage_i.valid && (stage_i.is_pixel == REQ_LOAD)
                     && (stage_i.slot == cell_index);
   assign entry_in = load_hit ? stage_i.color : entry_ff;

   // Keep the best so far; the first cell always takes its own entry, ties stay lower
   always_comb begin
      stage_in = stage_i;
      if ((cell_index == '0) || (len < stage_i.best_len)) begin
         stage_in.best_idx = cell_index;
         stage_in.best_len = len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;

endmodule
